/* rtl/core/keyframe_interpolator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Keyframe interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_INTERPOLATOR_UNIT_ASSERT_SVH
`define KEYFRAME_INTERPOLATOR_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define KFI_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define KFI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/core/kfi_pkg.sv */
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Widths, payload structs, table entry layout and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package kfi_pkg;

	localparam int MAX_KEYS       = 32;
	localparam int FRAME_BITS     = 16;
	localparam int VAL_W          = 32;
	localparam int IDX_W          = $clog2(MAX_KEYS);
	localparam int CNT_W          = $clog2(MAX_KEYS + 1);
	localparam int DEFAULT_LENGTH = 60;
	localparam int NUM_W          = FRAME_BITS + 1;
	localparam int SPAN_W         = FRAME_BITS + 1;
	localparam int PROD_W         = VAL_W + 1 + NUM_W;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_LENGTH = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	typedef struct packed {
		logic [1:0]              action;
		logic [FRAME_BITS-1:0]   frame;
		logic [FRAME_BITS-1:0]   new_length;
		logic signed [VAL_W-1:0] rotation_in;
		logic signed [VAL_W-1:0] scale_in;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] rotation_out;
		logic signed [VAL_W-1:0] scale_out;
		logic                    degenerate;
		logic                    table_full;
	} result_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0]   pos;
		logic signed [VAL_W-1:0] rot;
		logic signed [VAL_W-1:0] scl;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [SPAN_W-1:0] span;
	} lerp_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_WRITE,
		ST_LERP
	} kfi_state_t;

	typedef enum logic [1:0] {
		LP_IDLE,
		LP_MUL,
		LP_DIV,
		LP_FIN
	} lerp_state_t;

endpackage

`default_nettype wire

/* rtl/core/kfi_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/kfi_lerp.sv */
// ----------------------------------------------------------------------------
// Interpolation lane
// r0 + trunc((r1 - r0) * num / span) with a restoring divider, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module kfi_lerp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kfi_pkg::lerp_cmd_t                cmd,
	input  wire logic signed [kfi_pkg::VAL_W-1:0]  r0,
	input  wire logic signed [kfi_pkg::VAL_W-1:0]  r1,
	output logic                                   done,
	output logic signed [kfi_pkg::VAL_W-1:0]       res
);

	localparam int VAL_W  = kfi_pkg::VAL_W;
	localparam int NUM_W  = kfi_pkg::NUM_W;
	localparam int SPAN_W = kfi_pkg::SPAN_W;
	localparam int PROD_W = kfi_pkg::PROD_W;
	localparam int REM_W  = SPAN_W + 1;
	localparam int ITER_W = $clog2(PROD_W + 1);
	localparam int SUM_W  = PROD_W + 2;

	kfi_pkg::lerp_state_t state_q, state_d;

	logic                     neg_q;
	logic [VAL_W:0]           mag_q;
	logic signed [VAL_W-1:0]  r0_q;
	logic [NUM_W-1:0]         num_q;
	logic [SPAN_W-1:0]        span_q;
	logic [PROD_W-1:0]        dvd_q;
	logic [REM_W-1:0]         rem_q;
	logic [ITER_W-1:0]        iter_q;
	logic signed [VAL_W-1:0]  res_q;
	logic                     done_q;

	logic signed [VAL_W:0]    delta;
	logic [REM_W-1:0]         rem_sh;
	logic                     fits;
	logic signed [SUM_W-1:0]  sum;
	logic signed [VAL_W-1:0]  sat;

	assign delta  = {r1[VAL_W-1], r1} - {r0[VAL_W-1], r0};
	assign rem_sh = {rem_q[REM_W-2:0], dvd_q[PROD_W-1]};
	assign fits   = rem_sh >= {1'b0, span_q};

	always_comb begin
		sum = neg_q ? (SUM_W'(r0_q) - $signed({2'b00, dvd_q}))
			: (SUM_W'(r0_q) + $signed({2'b00, dvd_q}));
		if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
			sat = 32'sh7FFF_FFFF;
		end else if (sum < SUM_W'(32'sh8000_0000)) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = sum[VAL_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			kfi_pkg::LP_IDLE: begin
				if (cmd.start) begin
					state_d = kfi_pkg::LP_MUL;
				end
			end
			kfi_pkg::LP_MUL: state_d = kfi_pkg::LP_DIV;
			kfi_pkg::LP_DIV: begin
				if (iter_q == ITER_W'(PROD_W - 1)) begin
					state_d = kfi_pkg::LP_FIN;
				end
			end
			kfi_pkg::LP_FIN: state_d = kfi_pkg::LP_IDLE;
			default: state_d = kfi_pkg::LP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kfi_pkg::LP_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == kfi_pkg::LP_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			kfi_pkg::LP_IDLE: begin
				if (cmd.start) begin
					neg_q  <= delta[VAL_W];
					mag_q  <= delta[VAL_W] ? (VAL_W + 1)'(-delta) : delta;
					r0_q   <= r0;
					num_q  <= cmd.num;
					span_q <= cmd.span;
				end
			end
			kfi_pkg::LP_MUL: begin
				dvd_q  <= PROD_W'(mag_q) * PROD_W'(num_q);
				rem_q  <= '0;
				iter_q <= '0;
			end
			kfi_pkg::LP_DIV: begin
				// Dividend bits shift out the top while quotient bits fill the bottom.
				rem_q  <= fits ? (rem_sh - {1'b0, span_q}) : rem_sh;
				dvd_q  <= {dvd_q[PROD_W-2:0], fits};
				iter_q <= iter_q + ITER_W'(1);
			end
			kfi_pkg::LP_FIN: res_q <= sat;
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

/* rtl/core/keyframe_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// Keyframe interpolator unit
// Sorted keyframe table in RAM with insert, length cut and interpolated query.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Payload
// -------   --------------------   -----------------------------------------
// command   start in, busy out     cmd (kfi_pkg::cmd_t)
// result    done strobe out        result (kfi_pkg::result_t)
// config    cfg_valid / cfg_ready  cfg_data (loop mode bit)
//
// A command is taken when start is high and busy is low. Each command gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it, and a new command may be taken in the cycle its result is shown.
// Work per command, with N the number of stored keys: the table scan reads
// one entry per cycle from the single read port, at most N entries; a
// query adds the multiply and the 50-step divider; an insert adds a read
// state and a write state for each entry moved up. Action 3 skips the scan.
// No clearing pass after reset: only entry 0 is ever read before it is
// written, and a flag makes it read as zero until then.
//
`default_nettype none

`include "keyframe_interpolator_unit_assert.svh"

module keyframe_interpolator_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire kfi_pkg::cmd_t     cmd,
	output logic                   busy,
	output logic                   done,
	output kfi_pkg::result_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_data
);

	localparam int MAX_KEYS   = kfi_pkg::MAX_KEYS;
	localparam int FRAME_BITS = kfi_pkg::FRAME_BITS;
	localparam int IDX_W      = kfi_pkg::IDX_W;
	localparam int CNT_W      = kfi_pkg::CNT_W;
	localparam int NUM_W      = kfi_pkg::NUM_W;
	localparam int SPAN_W     = kfi_pkg::SPAN_W;

	kfi_pkg::kfi_state_t state_q, state_d;

	// Control state.
	kfi_pkg::cmd_t          cmd_q;
	logic [CNT_W-1:0]       count_q;
	logic [FRAME_BITS-1:0]  len_q;
	logic                   loop_q;
	logic [CNT_W-1:0]       issue_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_addr_s1;
	logic                   e0_wr_q;
	logic                   hit_q;
	logic                   eq_q;
	logic [CNT_W-1:0]       hit_idx_q;
	logic [CNT_W-1:0]       j_q;
	logic                   done_q;
	logic                   done_d;

	// Entries captured during the scan.
	kfi_pkg::entry_t        e0_q;
	kfi_pkg::entry_t        prev_q;
	kfi_pkg::entry_t        next_q;
	kfi_pkg::result_t       res_q;
	kfi_pkg::result_t       dec_res;

	// RAM ports.
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	kfi_pkg::entry_t            ram_wdata;
	logic [IDX_W-1:0]           ram_raddr;
	logic [kfi_pkg::ENTRY_W-1:0] ram_rdata;
	kfi_pkg::entry_t            rd_data;

	// Scan decode.
	logic                   issue_ok;
	logic                   ret;
	logic                   hit;
	logic                   last_ret;

	// Query decode.
	logic                   inner;
	kfi_pkg::entry_t        ka;
	kfi_pkg::entry_t        kb;
	logic [FRAME_BITS-1:0]  eff;
	logic [SPAN_W-1:0]      p0;
	logic [SPAN_W-1:0]      p1b;
	logic [SPAN_W-1:0]      p1;
	logic [SPAN_W-1:0]      f17;
	logic                   hold;
	logic                   degen;
	logic                   full;

	// Interpolation lanes.
	kfi_pkg::lerp_cmd_t           lerp_cmd;
	logic                         rot_done;
	logic                         scl_done;
	logic signed [kfi_pkg::VAL_W-1:0] rot_res;
	logic signed [kfi_pkg::VAL_W-1:0] scl_res;

	kfi_ram #(
		.WIDTH(kfi_pkg::ENTRY_W),
		.DEPTH(MAX_KEYS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	kfi_lerp u_lerp_rot (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (lerp_cmd),
		.r0    (ka.rot),
		.r1    (kb.rot),
		.done  (rot_done),
		.res   (rot_res)
	);

	kfi_lerp u_lerp_scl (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (lerp_cmd),
		.r0    (ka.scl),
		.r1    (kb.scl),
		.done  (scl_done),
		.res   (scl_res)
	);

	// Entry 0 reads as the all-zero key until the first write lands there.
	assign rd_data = ((rd_addr_s1 == '0) && !e0_wr_q) ? '0 : kfi_pkg::entry_t'(ram_rdata);

	assign issue_ok = (state_q == kfi_pkg::ST_SCAN) && (issue_q < count_q);
	assign ret      = (state_q == kfi_pkg::ST_SCAN) && rd_vld_s1;
	assign last_ret = {1'b0, rd_addr_s1} == (count_q - CNT_W'(1));

	// The scan stops at the first key past the target; a write also stops on
	// an equal position so that it replaces that key.
	always_comb begin
		case (cmd_q.action)
			kfi_pkg::ACT_WRITE:  hit = rd_data.pos >= cmd_q.frame;
			kfi_pkg::ACT_QUERY:  hit = rd_data.pos > cmd_q.frame;
			kfi_pkg::ACT_LENGTH: hit = rd_data.pos > cmd_q.new_length;
			default:             hit = 1'b0;
		endcase
	end

	// Query operands. A hit past entry 0 brackets the frame; otherwise the
	// last key (held in next_q) pairs with key 0, wrapped by the effective
	// length in loop mode, or simply held when looping is off.
	always_comb begin
		inner = hit_q && (hit_idx_q != '0);
		ka    = inner ? prev_q : next_q;
		kb    = inner ? next_q : e0_q;
		eff   = (next_q.pos > len_q) ? next_q.pos : len_q;
		p0    = {1'b0, ka.pos};
		p1b   = {1'b0, kb.pos};
		p1    = (p1b < p0) ? (p1b + {1'b0, eff}) : p1b;
		f17   = {1'b0, cmd_q.frame};
		hold  = !inner && !loop_q;
		degen = (p1 == p0) || (f17 < p0);
		full  = !(hit_q && eq_q) && (count_q == CNT_W'(MAX_KEYS));
	end

	// Result fields settled in the decide cycle.
	always_comb begin
		dec_res = '0;
		if (cmd_q.action == kfi_pkg::ACT_QUERY) begin
			if (hold) begin
				dec_res.rotation_out = next_q.rot;
				dec_res.scale_out    = next_q.scl;
			end else if (degen) begin
				dec_res.degenerate = 1'b1;
			end
		end else if (cmd_q.action == kfi_pkg::ACT_WRITE) begin
			dec_res.table_full = full;
		end
	end

	always_comb begin
		state_d        = state_q;
		done_d         = 1'b0;
		ram_we         = 1'b0;
		ram_waddr      = hit_idx_q[IDX_W-1:0];
		ram_wdata      = '{pos: cmd_q.frame, rot: cmd_q.rotation_in, scl: cmd_q.scale_in};
		ram_raddr      = issue_q[IDX_W-1:0];
		lerp_cmd.start = 1'b0;
		lerp_cmd.num   = NUM_W'(f17 - p0);
		lerp_cmd.span  = p1 - p0;
		case (state_q)
			kfi_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.action == kfi_pkg::ACT_NONE) begin
						done_d = 1'b1;
					end else begin
						state_d = kfi_pkg::ST_SCAN;
					end
				end
			end
			kfi_pkg::ST_SCAN: begin
				if (ret && (hit || last_ret)) begin
					state_d = kfi_pkg::ST_DECIDE;
				end
			end
			kfi_pkg::ST_DECIDE: begin
				case (cmd_q.action)
					kfi_pkg::ACT_QUERY: begin
						if (hold || degen) begin
							state_d = kfi_pkg::ST_IDLE;
							done_d  = 1'b1;
						end else begin
							lerp_cmd.start = 1'b1;
							state_d        = kfi_pkg::ST_LERP;
						end
					end
					kfi_pkg::ACT_WRITE: begin
						if (hit_q && eq_q) begin
							state_d = kfi_pkg::ST_WRITE;
						end else if (full) begin
							state_d = kfi_pkg::ST_IDLE;
							done_d  = 1'b1;
						end else if (hit_idx_q == count_q) begin
							state_d = kfi_pkg::ST_WRITE;
						end else begin
							state_d = kfi_pkg::ST_SHIFT_RD;
						end
					end
					default: begin
						state_d = kfi_pkg::ST_IDLE;
						done_d  = 1'b1;
					end
				endcase
			end
			kfi_pkg::ST_SHIFT_RD: begin
				ram_raddr = IDX_W'(j_q - CNT_W'(1));
				state_d   = kfi_pkg::ST_SHIFT_WR;
			end
			kfi_pkg::ST_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[IDX_W-1:0];
				ram_wdata = rd_data;
				state_d   = ((j_q - CNT_W'(1)) == hit_idx_q) ? kfi_pkg::ST_WRITE
					: kfi_pkg::ST_SHIFT_RD;
			end
			kfi_pkg::ST_WRITE: begin
				ram_we  = 1'b1;
				done_d  = 1'b1;
				state_d = kfi_pkg::ST_IDLE;
			end
			kfi_pkg::ST_LERP: begin
				if (rot_done) begin
					state_d = kfi_pkg::ST_IDLE;
					done_d  = 1'b1;
				end
			end
			default: state_d = kfi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kfi_pkg::ST_IDLE;
			count_q   <= CNT_W'(1);
			len_q     <= FRAME_BITS'(kfi_pkg::DEFAULT_LENGTH);
			loop_q    <= 1'b1;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			e0_wr_q   <= 1'b0;
			hit_q     <= 1'b0;
			eq_q      <= 1'b0;
			hit_idx_q <= '0;
			j_q       <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue_ok;
			done_q    <= done_d;
			if (cfg_valid && cfg_ready) begin
				loop_q <= cfg_data;
			end
			if (ram_we && (ram_waddr == '0)) begin
				e0_wr_q <= 1'b1;
			end
			if (issue_ok) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			case (state_q)
				kfi_pkg::ST_IDLE: issue_q <= '0;
				kfi_pkg::ST_SCAN: begin
					if (ret && hit) begin
						hit_q     <= 1'b1;
						eq_q      <= rd_data.pos == cmd_q.frame;
						hit_idx_q <= {1'b0, rd_addr_s1};
					end else if (ret && last_ret) begin
						hit_q     <= 1'b0;
						eq_q      <= 1'b0;
						hit_idx_q <= count_q;
					end
				end
				kfi_pkg::ST_DECIDE: begin
					j_q <= count_q;
					if (cmd_q.action == kfi_pkg::ACT_LENGTH) begin
						len_q <= cmd_q.new_length;
						if (hit_q) begin
							count_q <= hit_idx_q;
						end
					end
				end
				kfi_pkg::ST_SHIFT_WR: j_q <= j_q - CNT_W'(1);
				kfi_pkg::ST_WRITE: begin
					if (!(hit_q && eq_q)) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= ram_raddr;
		case (state_q)
			kfi_pkg::ST_IDLE: begin
				cmd_q <= cmd;
				res_q <= '0;
			end
			kfi_pkg::ST_SCAN: begin
				if (ret) begin
					if (rd_addr_s1 == '0) begin
						e0_q <= rd_data;
					end
					if (hit || last_ret) begin
						next_q <= rd_data;
					end else begin
						prev_q <= rd_data;
					end
				end
			end
			kfi_pkg::ST_DECIDE: res_q <= dec_res;
			kfi_pkg::ST_LERP: begin
				if (rot_done) begin
					res_q <= '{rotation_out: rot_res, scale_out: scl_res,
						degenerate: 1'b0, table_full: 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Action 3 reports from the idle cycle, so its result is all zero.
	assign busy      = (state_q != kfi_pkg::ST_IDLE);
	assign done      = done_q;
	assign result    = (state_q == kfi_pkg::ST_IDLE && done_q && cmd_q.action == kfi_pkg::ACT_NONE)
		? '0 : res_q;
	assign cfg_ready = 1'b1;

	`KFI_ASSERT_ALWAYS(a_count_range, (count_q != '0) && (count_q <= CNT_W'(MAX_KEYS)), "key count out of range")
	`KFI_ASSERT_NEXT(a_start_busy, start && !busy, busy || done, "accepted command neither busy nor done")
	`KFI_ASSERT_ALWAYS(a_lanes_sync, rot_done == scl_done, "interpolation lanes out of step")

endmodule

`default_nettype wire
